// ===== hdl/pfb_pkg.sv =====
// Shared types, constants and register codes of the pixel format to BGRA converter.
`timescale 1ns / 1ps
`default_nettype none

package pfb_pkg;

   // Pixel byte and control port widths
   localparam int PIX_W      = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int FMT_W      = 2;

   // Q16 BT.601 coefficients, unsigned
   localparam int COEF_W = 17;
   localparam logic [COEF_W-1:0] COEF_RV = 17'd91881;
   localparam logic [COEF_W-1:0] COEF_GU = 17'd22545;
   localparam logic [COEF_W-1:0] COEF_GV = 17'd46793;
   localparam logic [COEF_W-1:0] COEF_BU = 17'd116130;

   // Widths of one colour term and of the unclamped sum
   localparam int TERM_W = 10;
   localparam int SUM_W  = 11;

   localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // Register indexes
   localparam logic [CSR_ADDR_W-3:0] REG_PIXEL_FORMAT = 1'b0;

   typedef logic [PIX_W-1:0] byte_type;

   typedef enum logic [FMT_W-1:0] {
      FMT_BGRA8  = 2'd0,
      FMT_RGBA8  = 2'd1,
      FMT_RGB8   = 2'd2,
      FMT_YUV420 = 2'd3
   } format_type;

   // One source pixel as taken from the input channel
   typedef struct packed {
      byte_type byte_a;
      byte_type byte_b;
      byte_type byte_c;
      byte_type byte_d;
      logic     end_of_frame;
   } req_type;

   // One BGRA pixel as handed to the result channel
   typedef struct packed {
      byte_type blue;
      byte_type green;
      byte_type red;
      byte_type alpha;
      logic     last_pixel;
   } rsp_type;

   // Luma and raw chroma samples into the colour converter
   typedef struct packed {
      byte_type y;
      byte_type u;
      byte_type v;
   } yuv_type;

   // Clamped colour bytes out of the colour converter
   typedef struct packed {
      byte_type blue;
      byte_type green;
      byte_type red;
   } bgr_type;

endpackage

`default_nettype wire

// ===== hdl/pfb_if.sv =====
// Valid/ready channel interfaces for source pixels and BGRA result pixels.
`timescale 1ns / 1ps
`default_nettype none

interface pfb_req_if;
   import pfb_pkg::*;

   logic     valid;
   logic     ready;
   byte_type byte_a;
   byte_type byte_b;
   byte_type byte_c;
   byte_type byte_d;
   logic     end_of_frame;

   modport source (output valid, output byte_a, output byte_b, output byte_c,
                   output byte_d, output end_of_frame, input ready);
   modport sink   (input valid, input byte_a, input byte_b, input byte_c,
                   input byte_d, input end_of_frame, output ready);
endinterface

interface pfb_rsp_if;
   import pfb_pkg::*;

   logic     valid;
   logic     ready;
   byte_type blue;
   byte_type green;
   byte_type red;
   byte_type alpha;
   logic     last_pixel;

   modport source (output valid, output blue, output green, output red,
                   output alpha, output last_pixel, input ready);
   modport sink   (input valid, input blue, input green, input red,
                   input alpha, input last_pixel, output ready);
endinterface

`default_nettype wire

// ===== hdl/pfb_yuv.sv =====
// BT.601 YUV to RGB colour converter with Q16 coefficients and byte clamping.
`timescale 1ns / 1ps
`default_nettype none

module pfb_yuv (
   input  pfb_pkg::yuv_type yuv_in,
   output pfb_pkg::bgr_type bgr_out
);
   import pfb_pkg::*;

   // Coefficient times |s|, shifted down by 16, sign restored (truncates toward zero)
   function automatic logic signed [TERM_W-1:0] q16_term(
      input logic [COEF_W-1:0]       coef,
      input logic signed [PIX_W-1:0] s
   );
      logic [PIX_W-1:0]          mag;
      logic [COEF_W+PIX_W-1:0]   prod;
      logic [PIX_W:0]            trunc;
      logic signed [TERM_W-1:0]  pos;
      mag   = s[PIX_W-1] ? PIX_W'(-s) : PIX_W'(s);
      prod  = (COEF_W+PIX_W)'(coef) * (COEF_W+PIX_W)'(mag);
      trunc = prod[COEF_W+PIX_W-1:16];
      pos   = signed'(TERM_W'(trunc));
      return s[PIX_W-1] ? -pos : pos;
   endfunction

   // Clamp a signed sum to 0..255
   function automatic byte_type clamp_byte(input logic signed [SUM_W-1:0] x);
      byte_type res;
      if (x < 0) begin
         res = '0;
      end else if (x > SUM_W'(signed'(255))) begin
         res = '1;
      end else begin
         res = x[PIX_W-1:0];
      end
      return res;
   endfunction

   logic signed [PIX_W-1:0]  u_s;
   logic signed [PIX_W-1:0]  v_s;
   logic signed [SUM_W-1:0]  y_s;
   logic signed [TERM_W-1:0] t_rv;
   logic signed [TERM_W-1:0] t_gu;
   logic signed [TERM_W-1:0] t_gv;
   logic signed [TERM_W-1:0] t_bu;
   logic signed [SUM_W-1:0]  red_sum;
   logic signed [SUM_W-1:0]  green_sum;
   logic signed [SUM_W-1:0]  blue_sum;

   // Remove the chroma offset of 128 by flipping the top bit
   assign u_s = signed'({~yuv_in.u[PIX_W-1], yuv_in.u[PIX_W-2:0]});
   assign v_s = signed'({~yuv_in.v[PIX_W-1], yuv_in.v[PIX_W-2:0]});
   assign y_s = signed'(SUM_W'(yuv_in.y));

   // One product per colour term
   assign t_rv = q16_term(COEF_RV, v_s);
   assign t_gu = q16_term(COEF_GU, u_s);
   assign t_gv = q16_term(COEF_GV, v_s);
   assign t_bu = q16_term(COEF_BU, u_s);

   // Sum and clamp each channel
   assign red_sum   = y_s + SUM_W'(t_rv);
   assign green_sum = y_s - SUM_W'(t_gu) - SUM_W'(t_gv);
   assign blue_sum  = y_s + SUM_W'(t_bu);

   assign bgr_out.red   = clamp_byte(red_sum);
   assign bgr_out.green = clamp_byte(green_sum);
   assign bgr_out.blue  = clamp_byte(blue_sum);

endmodule

`default_nettype wire

// ===== hdl/pixel_format_to_bgra.sv =====
// Top level of the pixel format to BGRA converter: channels, register and pipeline.
//
// Use: each item on req_ch carries one source pixel (four bytes and an
// end-of-frame flag); each item on rsp_ch carries one BGRA pixel and the
// copied flag. Every input item gives exactly one result item, in order.
// The pixel_format register (byte address 0 on the csr_ APB port) picks the
// source layout: BGRA8, RGBA8, RGB8 or YUV420 (BT.601, Q16, clamped).
// Write it only while no items are in flight.
// Path: a pixel accepted on req_ch passes the input register, then the result
// register, before it is offered on rsp_ch.
// Throughput: one pixel per clock with rsp_ch.ready high, set by the two-register
// pipeline with a single pass of four small multipliers and clamps between them.
// Stall: while rsp_ch.ready is low a full result register holds; if the input
// register is empty, one more pixel is taken into it, then req_ch.ready drops.
// Reset: clears both valid flags and sets pixel_format to BGRA8.
`timescale 1ns / 1ps
`default_nettype none

module pixel_format_to_bgra (
   input  logic                                 clock,
   input  logic                                 reset,
   pfb_req_if.sink                              req_ch,
   pfb_rsp_if.source                            rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pfb_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [pfb_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [pfb_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import pfb_pkg::*;

   format_type format_ff, format_in;
   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff, in_data_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;

   logic       out_take;
   logic       in_take;
   logic       csr_write;
   logic       csr_hit;
   yuv_type    yuv;
   bgr_type    yuv_bgr;
   rsp_type    conv;

   // Register access
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1:2] == REG_PIXEL_FORMAT;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(format_ff) : '0;

   always_comb begin
      format_in = format_ff;
      if (csr_write) begin
         format_in = format_type'(csr_pwdata[FMT_W-1:0]);
      end
   end

   // Pipeline handshake: result register frees when empty or taken
   assign out_take     = !out_valid_ff || rsp_ch.ready;
   assign in_take      = !in_valid_ff || out_take;
   assign req_ch.ready = in_take;

   always_comb begin
      in_valid_in  = in_take ? req_ch.valid : in_valid_ff;
      out_valid_in = out_take ? in_valid_ff : out_valid_ff;
   end

   // Capture the source pixel
   always_comb begin
      in_data_in = in_data_ff;
      if (in_take) begin
         in_data_in.byte_a       = req_ch.byte_a;
         in_data_in.byte_b       = req_ch.byte_b;
         in_data_in.byte_c       = req_ch.byte_c;
         in_data_in.byte_d       = req_ch.byte_d;
         in_data_in.end_of_frame = req_ch.end_of_frame;
      end
   end

   // Colour conversion for YUV420
   assign yuv.y = in_data_ff.byte_a;
   assign yuv.u = in_data_ff.byte_b;
   assign yuv.v = in_data_ff.byte_c;

   pfb_yuv u_yuv (
      .yuv_in  (yuv),
      .bgr_out (yuv_bgr)
   );

   // Rearrange bytes by source format
   always_comb begin
      conv.last_pixel = in_data_ff.end_of_frame;
      case (format_ff)
         FMT_BGRA8: begin
            conv.blue  = in_data_ff.byte_a;
            conv.green = in_data_ff.byte_b;
            conv.red   = in_data_ff.byte_c;
            conv.alpha = in_data_ff.byte_d;
         end
         FMT_RGBA8: begin
            conv.blue  = in_data_ff.byte_c;
            conv.green = in_data_ff.byte_b;
            conv.red   = in_data_ff.byte_a;
            conv.alpha = in_data_ff.byte_d;
         end
         FMT_RGB8: begin
            conv.blue  = in_data_ff.byte_c;
            conv.green = in_data_ff.byte_b;
            conv.red   = in_data_ff.byte_a;
            conv.alpha = ALPHA_OPAQUE;
         end
         default: begin
            conv.blue  = yuv_bgr.blue;
            conv.green = yuv_bgr.green;
            conv.red   = yuv_bgr.red;
            conv.alpha = ALPHA_OPAQUE;
         end
      endcase
   end

   // Load the result register when it is free
   assign out_data_in = out_take ? conv : out_data_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= FMT_BGRA8;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         format_ff    <= format_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   // Drive the result channel
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.blue       = out_data_ff.blue;
   assign rsp_ch.green      = out_data_ff.green;
   assign rsp_ch.red        = out_data_ff.red;
   assign rsp_ch.alpha      = out_data_ff.alpha;
   assign rsp_ch.last_pixel = out_data_ff.last_pixel;

endmodule

`default_nettype wire
